FILE: rtl/core/lrfr_pkg.sv
package lrfr_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;

  localparam logic [7:0] HDR_MARK  = 8'h3C;
  localparam logic [7:0] TAIL_HEAD = 8'h80;
  localparam logic [7:0] TAIL_END  = 8'h7F;
  localparam int         FRAME_BYTES = 12;
  localparam int         WORD_BYTES  = 4;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_POP   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_IGNORED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_OPEN    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_STAMP,
    S_TAIL,
    S_POP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic exec;
    logic stamp;
    logic tail;
    logic pop_cap;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic begin_ok;
    logic pop_ok;
  } stat_t;

endpackage

FILE: rtl/core/lrfr_ctrl.sv
module lrfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lrfr_pkg::stat_t stat,
  output lrfr_pkg::cmd_t  cmd
);

  lrfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrfr_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrfr_pkg::S_CLEAR: begin
        if (stat.clear_done) state_nxt = lrfr_pkg::S_IDLE;
      end
      lrfr_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lrfr_pkg::S_EXEC;
      end
      lrfr_pkg::S_EXEC: begin
        if (stat.begin_ok) begin
          state_nxt = lrfr_pkg::S_STAMP;
        end else if (stat.pop_ok) begin
          state_nxt = lrfr_pkg::S_POP;
        end else begin
          state_nxt = lrfr_pkg::S_RESP;
        end
      end
      lrfr_pkg::S_STAMP: state_nxt = lrfr_pkg::S_TAIL;
      lrfr_pkg::S_TAIL:  state_nxt = lrfr_pkg::S_RESP;
      lrfr_pkg::S_POP:   state_nxt = lrfr_pkg::S_RESP;
      lrfr_pkg::S_RESP: begin
        if (!out_stall) state_nxt = lrfr_pkg::S_IDLE;
      end
      default: state_nxt = lrfr_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      lrfr_pkg::S_CLEAR: cmd.clear = 1'b1;
      lrfr_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      lrfr_pkg::S_EXEC:  cmd.exec    = 1'b1;
      lrfr_pkg::S_STAMP: cmd.stamp   = 1'b1;
      lrfr_pkg::S_TAIL:  cmd.tail    = 1'b1;
      lrfr_pkg::S_POP:   cmd.pop_cap = 1'b1;
      lrfr_pkg::S_RESP:  out_valid   = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a transaction taken in never shows its result on the very next edge
  a_no_same_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown directly after accept");

  // framing words are written in a fixed order
  a_tail_after_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stamp |=> cmd.tail)
    else $error("stamp word not followed by tail word");
`endif

endmodule

FILE: rtl/core/lrfr_datapath.sv
module lrfr_datapath #(
  parameter int BUFFER_BYTES = lrfr_pkg::BUFFER_BYTES_DEF,
  parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lrfr_pkg::cmd_t  cmd,
  output lrfr_pkg::stat_t stat,
  input  logic [1:0]      in_operation,
  input  logic [7:0]      in_record_length,
  input  logic [7:0]      in_file_number,
  input  logic [7:0]      in_record_type,
  input  logic [23:0]     in_tick_time,
  input  logic            in_is_make_file,
  input  logic [7:0]      in_data_byte,
  output logic [2:0]      out_status,
  output logic [31:0]     out_read_word,
  output logic [CW-1:0]   out_stored_bytes
);

  localparam int NWORDS = BUFFER_BYTES / lrfr_pkg::WORD_BYTES;
  localparam int AW     = $clog2(NWORDS);
  localparam int SW     = AW + 8;
  localparam int CMPW   = (CW > 9) ? CW + 1 : 10;

  // word wide ring, byte lanes written through enables
  logic [31:0] mem [NWORDS];

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] wr_ptr_r;
  logic [CW-1:0] used_r;
  logic [AW-1:0] fill_w_r;
  logic [1:0]    fill_lane_r;
  logic [7:0]    left_r;

  logic [1:0]  op_r;
  logic [7:0]  len_r;
  logic [7:0]  file_r;
  logic [7:0]  type_r;
  logic [23:0] tick_r;
  logic        make_r;
  logic [7:0]  data_r;

  lrfr_pkg::status_t status_r, status_nxt;
  logic [31:0] word_r;
  logic [31:0] rd_data_r;

  logic [6:0]      padw;
  logic [CMPW-1:0] free_c, len12_c, reserve_c;
  logic            open_rec, nospace, begin_ok, data_ok, pop_ok;
  logic [AW-1:0]   stamp_a, tail_a, fill_start_a, next_wr_a, next_rd_a, next_fill_a;

  logic          mem_we;
  logic [3:0]    mem_be;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  function automatic logic [AW-1:0] wrap_w(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(NWORDS)) ? s - SW'(NWORDS) : s;
    return r[AW-1:0];
  endfunction

  always_comb begin
    padw      = 7'((9'(len_r) + 9'd3) >> 2);
    free_c    = CMPW'(BUFFER_BYTES) - CMPW'(used_r);
    len12_c   = CMPW'(len_r) + CMPW'(lrfr_pkg::FRAME_BYTES);
    reserve_c = CMPW'(lrfr_pkg::FRAME_BYTES) + CMPW'({padw, 2'b00});
    nospace   = (free_c <= len12_c) || (free_c < reserve_c);
    open_rec  = (left_r != 8'd0);
    begin_ok  = (op_r == lrfr_pkg::OP_BEGIN) && !open_rec && !nospace;
    data_ok   = (op_r == lrfr_pkg::OP_DATA) && open_rec;
    pop_ok    = (op_r == lrfr_pkg::OP_POP) && !open_rec && (used_r[CW-1:2] != '0);

    stamp_a      = wrap_w(SW'(wr_ptr_r) + SW'(1));
    fill_start_a = wrap_w(SW'(wr_ptr_r) + SW'(2));
    tail_a       = wrap_w(SW'(wr_ptr_r) + SW'(2) + SW'(padw));
    next_wr_a    = wrap_w(SW'(wr_ptr_r) + SW'(3) + SW'(padw));
    next_rd_a    = wrap_w(SW'(rd_ptr_r) + SW'(1));
    next_fill_a  = wrap_w(SW'(fill_w_r) + SW'(1));
  end

  always_comb begin
    status_nxt = lrfr_pkg::ST_IGNORED;
    case (op_r)
      lrfr_pkg::OP_BEGIN: begin
        if (open_rec) begin
          status_nxt = lrfr_pkg::ST_OPEN;
        end else if (nospace) begin
          status_nxt = lrfr_pkg::ST_NOSPACE;
        end else begin
          status_nxt = lrfr_pkg::ST_OK;
        end
      end
      lrfr_pkg::OP_DATA: begin
        status_nxt = open_rec ? lrfr_pkg::ST_OK : lrfr_pkg::ST_IGNORED;
      end
      lrfr_pkg::OP_POP: begin
        if (open_rec) begin
          status_nxt = lrfr_pkg::ST_OPEN;
        end else if (!pop_ok) begin
          status_nxt = lrfr_pkg::ST_EMPTY;
        end else begin
          status_nxt = lrfr_pkg::ST_OK;
        end
      end
      default: status_nxt = lrfr_pkg::ST_IGNORED;
    endcase
  end

  // single write port shared by clearing, framing and payload writes
  always_comb begin
    mem_we    = 1'b0;
    mem_be    = 4'h0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_be    = 4'hF;
      mem_waddr = clr_cnt_r;
    end else if (cmd.exec && begin_ok) begin
      mem_we    = 1'b1;
      mem_be    = 4'hF;
      mem_waddr = wr_ptr_r;
      mem_wdata = {lrfr_pkg::HDR_MARK, len_r, len_r, lrfr_pkg::HDR_MARK};
    end else if (cmd.exec && data_ok) begin
      mem_we    = 1'b1;
      mem_be    = 4'b0001 << fill_lane_r;
      mem_waddr = fill_w_r;
      mem_wdata = {4{data_r}};
    end else if (cmd.stamp) begin
      mem_we    = 1'b1;
      mem_be    = 4'hF;
      mem_waddr = stamp_a;
      mem_wdata = make_r ? 32'd0 : {type_r, tick_r};
    end else if (cmd.tail) begin
      mem_we    = 1'b1;
      mem_be    = 4'hF;
      mem_waddr = tail_a;
      mem_wdata = {lrfr_pkg::TAIL_END, file_r, file_r, lrfr_pkg::TAIL_HEAD};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++) begin
        if (mem_be[i]) mem[mem_waddr][8*i +: 8] <= mem_wdata[8*i +: 8];
      end
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      used_r      <= '0;
      fill_w_r    <= '0;
      fill_lane_r <= '0;
      left_r      <= '0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.exec && data_ok) begin
        fill_lane_r <= fill_lane_r + 2'd1;
        if (fill_lane_r == 2'd3) fill_w_r <= next_fill_a;
        left_r <= left_r - 8'd1;
      end
      if (cmd.exec && pop_ok) begin
        rd_ptr_r <= next_rd_a;
        used_r   <= used_r - CW'(lrfr_pkg::WORD_BYTES);
      end
      if (cmd.tail) begin
        wr_ptr_r    <= next_wr_a;
        used_r      <= used_r + CW'(reserve_c);
        fill_w_r    <= fill_start_a;
        fill_lane_r <= 2'd0;
        left_r      <= len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      len_r  <= in_record_length;
      file_r <= in_file_number;
      type_r <= in_record_type;
      tick_r <= in_tick_time;
      make_r <= in_is_make_file;
      data_r <= in_data_byte;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      word_r   <= '0;
    end
    if (cmd.pop_cap) word_r <= rd_data_r;
  end

  always_comb begin
    stat.clear_done = cmd.clear && (clr_cnt_r == AW'(NWORDS - 1));
    stat.begin_ok   = begin_ok;
    stat.pop_ok     = pop_ok;
  end

  assign out_status       = status_r;
  assign out_read_word    = word_r;
  assign out_stored_bytes = used_r;

`ifndef SYNTHESIS
  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(BUFFER_BYTES))
    else $error("stored byte count beyond ring size");

  a_used_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[1:0] == 2'b00)
    else $error("stored byte count not whole words");

  a_empty_pointers_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty ring with read and write pointers apart");
`endif

endmodule

FILE: rtl/core/log_record_framer_ring_unit.sv
// log record framer on a byte ring
// input channel (in_valid/in_stall) takes one transaction per item: begin record,
// payload data byte or pop of one stored word; in_operation selects which.
// output channel (out_valid/out_stall) returns exactly one result per item:
// out_status, out_read_word (popped word, lowest ring byte in bits 7:0) and
// out_stored_bytes (ring fill after the item).
// a begin that fits writes header, stamp and tail words, one per cycle through
// the single write port of the word memory in the states EXEC, STAMP and TAIL,
// after which the result is shown in RESP.
// a pop reads through the registered memory port: EXEC, then POP captures the
// word, then RESP. data bytes and refused items go from EXEC straight to RESP.
// one item is in work at a time.
// after reset the ring is zeroed word by word with in_stall held high;
// pointers, fill count and open record are cleared.
// while out_stall is high the result holds and no new transaction is taken.
// BUFFER_BYTES must be a multiple of 4.
module log_record_framer_ring_unit #(
  parameter int BUFFER_BYTES = lrfr_pkg::BUFFER_BYTES_DEF,
  parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_record_length,
  input  logic [7:0]    in_file_number,
  input  logic [7:0]    in_record_type,
  input  logic [23:0]   in_tick_time,
  input  logic          in_is_make_file,
  input  logic [7:0]    in_data_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic [31:0]   out_read_word,
  output logic [CW-1:0] out_stored_bytes
);

  lrfr_pkg::cmd_t  cmd;
  lrfr_pkg::stat_t stat;

  lrfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrfr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .CW           (CW)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_record_length (in_record_length),
    .in_file_number   (in_file_number),
    .in_record_type   (in_record_type),
    .in_tick_time     (in_tick_time),
    .in_is_make_file  (in_is_make_file),
    .in_data_byte     (in_data_byte),
    .out_status       (out_status),
    .out_read_word    (out_read_word),
    .out_stored_bytes (out_stored_bytes)
  );

endmodule

FILE: verif/lrfr_ring_checker.sv
`timescale 1ns / 1ps
module lrfr_ring_checker #(
  parameter int BUFFER_BYTES = lrfr_pkg::BUFFER_BYTES_DEF,
  parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_record_length,
  input  logic [7:0]    in_file_number,
  input  logic [7:0]    in_record_type,
  input  logic [23:0]   in_tick_time,
  input  logic          in_is_make_file,
  input  logic [7:0]    in_data_byte,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [2:0]    out_status,
  input  logic [31:0]   out_read_word,
  input  logic [CW-1:0] out_stored_bytes,
  output int            fail_count,
  output int            replies_owed
);
  import lrfr_pkg::*;

  typedef struct packed {
    status_t       status;
    logic [31:0]   word;
    logic [CW-1:0] stored;
  } ring_reply_t;

  logic [7:0]  ring_bytes [BUFFER_BYTES];
  int          rd_pos;
  int          wr_pos;
  int          fill_pos;
  int          used_bytes;
  int          bytes_owed;
  int          fail_total;
  ring_reply_t ring_replies [$];

  initial begin
    foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
    rd_pos     = 0;
    wr_pos     = 0;
    fill_pos   = 0;
    used_bytes = 0;
    bytes_owed = 0;
    fail_total = 0;
  end

  function automatic int wrap(input int pos);
    return pos % BUFFER_BYTES;
  endfunction

  // byte 0 of the word lands at the lowest ring address
  task automatic put_word(input int pos, input logic [31:0] word);
    for (int k = 0; k < WORD_BYTES; k++) ring_bytes[wrap(pos + k)] = word[8*k +: 8];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ring check: %s: got %0h, expected %0h", $time, what, got, want);
    fail_total++;
  endtask

  task automatic predict_ring_step(output ring_reply_t reply);
    int         free_bytes;
    int         padded;
    int         reserve;
    logic [7:0] len;
    reply.status = ST_IGNORED;
    reply.word   = 32'h0;
    len          = in_record_length;
    case (in_operation)
      OP_BEGIN: begin
        if (bytes_owed != 0) begin
          reply.status = ST_OPEN;
        end else begin
          free_bytes = BUFFER_BYTES - used_bytes;
          padded     = (int'(len) + 3) & ~3;
          reserve    = FRAME_BYTES + padded;
          if (free_bytes <= int'(len) + FRAME_BYTES || free_bytes < reserve) begin
            reply.status = ST_NOSPACE;
          end else begin
            put_word(wr_pos, {HDR_MARK, len, len, HDR_MARK});
            put_word(wr_pos + 4, in_is_make_file ? 32'h0 : {in_record_type, in_tick_time});
            put_word(wr_pos + 8 + padded,
                     {TAIL_END, in_file_number, in_file_number, TAIL_HEAD});
            fill_pos   = wrap(wr_pos + 8);
            bytes_owed = int'(len);
            wr_pos     = wrap(wr_pos + reserve);
            used_bytes += reserve;
            reply.status = ST_OK;
          end
        end
      end
      OP_DATA: begin
        if (bytes_owed != 0) begin
          ring_bytes[fill_pos] = in_data_byte;
          fill_pos   = wrap(fill_pos + 1);
          bytes_owed--;
          reply.status = ST_OK;
        end
      end
      OP_POP: begin
        if (bytes_owed != 0) begin
          reply.status = ST_OPEN;
        end else if (used_bytes < WORD_BYTES) begin
          reply.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < WORD_BYTES; k++) reply.word[8*k +: 8] = ring_bytes[wrap(rd_pos + k)];
          rd_pos     = wrap(rd_pos + WORD_BYTES);
          used_bytes -= WORD_BYTES;
          reply.status = ST_OK;
        end
      end
      default: reply.status = ST_IGNORED;
    endcase
    reply.stored = CW'(used_bytes);
  endtask

  always @(posedge clk) begin : watch
    ring_reply_t due;
    if (rst_n) begin
      // results first, so a stray one is not matched against a transaction taken this edge
      if (out_valid && !out_stall) begin
        if (ring_replies.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(out_status), 32'h0);
        end else begin
          due = ring_replies.pop_front();
          if (out_status != due.status)
            report_mismatch("status", 32'(out_status), 32'(due.status));
          if (out_read_word != due.word) report_mismatch("read word", out_read_word, due.word);
          if (out_stored_bytes != due.stored)
            report_mismatch("stored bytes", 32'(out_stored_bytes), 32'(due.stored));
        end
      end
      if (in_valid && !in_stall) begin
        predict_ring_step(due);
        ring_replies.push_back(due);
      end
    end
    fail_count   <= fail_total;
    replies_owed <= ring_replies.size();
  end

endmodule

FILE: verif/log_record_framer_ring_unit_test.sv
`timescale 1ns / 1ps
module log_record_framer_ring_unit_test;
  import lrfr_pkg::*;

  localparam int         CW          = $clog2(BUFFER_BYTES_DEF + 1);
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEMS       = 1200;
  localparam int         HOLD_CYCLES = 200;
  localparam int         STALL_LIMIT = 3000;

  logic          clk              = 1'b0;
  logic          rst_n            = 1'b0;
  logic          in_valid         = 1'b0;
  logic          in_stall;
  logic [1:0]    in_operation     = OP_BEGIN;
  logic [7:0]    in_record_length = 8'h00;
  logic [7:0]    in_file_number   = 8'h00;
  logic [7:0]    in_record_type   = 8'h00;
  logic [23:0]   in_tick_time     = 24'h0;
  logic          in_is_make_file  = 1'b0;
  logic [7:0]    in_data_byte     = 8'h00;
  logic          out_valid;
  logic          out_stall        = 1'b0;
  logic [2:0]    out_status;
  logic [31:0]   out_read_word;
  logic [CW-1:0] out_stored_bytes;

  int fail_count;
  int replies_owed;
  int items_sent     = 0;
  int send_gap_pct   = 20;
  int recv_stall_pct = 74;
  int holds_asked    = 0;
  int quiet_cycles   = 0;

  always #10 clk = ~clk;

  log_record_framer_ring_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_record_length (in_record_length),
    .in_file_number   (in_file_number),
    .in_record_type   (in_record_type),
    .in_tick_time     (in_tick_time),
    .in_is_make_file  (in_is_make_file),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_word    (out_read_word),
    .out_stored_bytes (out_stored_bytes)
  );

  lrfr_ring_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_record_length (in_record_length),
    .in_file_number   (in_file_number),
    .in_record_type   (in_record_type),
    .in_tick_time     (in_tick_time),
    .in_is_make_file  (in_is_make_file),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_word    (out_read_word),
    .out_stored_bytes (out_stored_bytes),
    .fail_count       (fail_count),
    .replies_owed     (replies_owed)
  );

  // receiver: random stall, or a long hold-off when one is asked for
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("log_record_framer_ring_unit: mismatch");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] len, input logic [7:0] file,
                           input logic [7:0] rtype, input logic [23:0] tick,
                           input logic make, input logic [7:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_record_length <= len;
    in_file_number   <= file;
    in_record_type   <= rtype;
    in_tick_time     <= tick;
    in_is_make_file  <= make;
    in_data_byte     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic open_record(input logic [7:0] len);
    send_item(OP_BEGIN, len, 8'($urandom), 8'($urandom), 24'($urandom),
              $urandom_range(3) == 0, 8'($urandom));
  endtask

  task automatic put_payload(input int count);
    repeat (count) send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                             24'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic pop_words(input int count);
    repeat (count) send_item(OP_POP, 8'($urandom), 8'($urandom), 8'($urandom),
                             24'($urandom), 1'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] len;
    int         part;
    bit         filled;
    filled = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, stray data, unused operation
    send_item(OP_POP, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h00);
    send_item(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h00);
    // empty record with all-ones fields, read straight back
    send_item(OP_BEGIN, 8'd0, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0, 8'h00);
    pop_words(3);
    // make-file record; begin and pop while it is still open
    send_item(OP_BEGIN, 8'd5, 8'h00, 8'h00, 24'h0, 1'b1, 8'hFF);
    send_item(OP_BEGIN, 8'd9, 8'h12, 8'h34, 24'h567890, 1'b0, 8'h00);
    send_item(OP_POP, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'hFF);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'hA5);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h5A);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0, 8'h01);
    // padding keeps old bytes; last pop finds the ring empty
    pop_words(6);

    while (items_sent < ITEMS) begin
      if (items_sent < 350) begin
        send_gap_pct   = 20;
        recv_stall_pct = 74;
      end else if (items_sent < 700) begin
        send_gap_pct   = 74;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (items_sent >= 700 && !filled) begin
        // fill the ring to refusal while the receiver holds off
        filled = 1'b1;
        holds_asked <= holds_asked + 1;
        open_record(8'd255);
        put_payload(255);
        repeat (60) begin
          len = 8'($urandom_range(0, 3));
          open_record(len);
          put_payload(int'(len));
        end
      end
      part = $urandom_range(99);
      if (part < 55) begin
        case ($urandom_range(19))
          0:             len = 8'($urandom_range(128, 255));
          1, 2, 3, 4, 5: len = 8'($urandom_range(17, 80));
          default:       len = 8'($urandom_range(0, 16));
        endcase
        open_record(len);
        if ($urandom_range(9) == 0) begin
          // broken record: something else arrives before the payload is complete
          put_payload(int'(len / 2));
          if ($urandom_range(1)) pop_words(1);
          else open_record(8'($urandom));
          put_payload(int'(len - len / 2));
        end else begin
          put_payload(int'(len));
        end
      end else if (part < 90) begin
        pop_words($urandom_range(1, 40));
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                  24'($urandom), 1'($urandom), 8'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("log_record_framer_ring_unit: match");
    end else begin
      $display("log_record_framer_ring_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: log_record_framer_ring_unit.f
rtl/core/lrfr_pkg.sv
rtl/core/lrfr_ctrl.sv
rtl/core/lrfr_datapath.sv
rtl/core/log_record_framer_ring_unit.sv
verif/lrfr_ring_checker.sv
verif/log_record_framer_ring_unit_test.sv
